[rtl/core/bm3_pkg.sv]
// bm3_pkg: shared types and constants for the 3x3 binary morphology block.
// Holds configuration register indexes, reset values and the result beat type.
// No dependencies.
`default_nettype none

package bm3_pkg;

    // Configuration port geometry
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;

    // Register indexes on the configuration port
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MODE   = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } cfg_index_t;

    // Operating modes
    localparam logic MODE_ERODE  = 1'b0;
    localparam logic MODE_DILATE = 1'b1;

    // Border byte for each mode
    localparam logic [7:0] BORDER_ERODE  = 8'd1;
    localparam logic [7:0] BORDER_DILATE = 8'd0;

    // Reset values of the configuration registers
    localparam logic                  MODE_RESET   = MODE_ERODE;
    localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 11'd480;

    // Default line store depth
    localparam int MAX_WIDTH_DEF = 1024;

    // Row counter covers the frame plus the drain rows at the largest height
    localparam int ROW_W = 12;

    // Result queue depth
    localparam int QUEUE_DEPTH = 4;

    // Input item kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    // One result beat
    typedef struct packed {
        logic [7:0] out_pixel;
        logic       end_of_frame;
    } result_t;

    // Per-item control carried from the read stage to the update stage
    typedef struct packed {
        logic first_col;
        logic row_ge1;
        logic row_ge2;
        logic drain;
        logic emit;
        logic finish;
    } stage_ctrl_t;

endpackage

`default_nettype wire

[rtl/core/bm3_if.sv]
// bm3_if: valid/ready stream interfaces for the pixel input and result output.
// Standalone; used by binary_morphology_3x3 and its environment.
`default_nettype none

interface bm3_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] pixel;

    modport source (output valid, output kind, output pixel, input ready);
    modport sink   (input valid, input kind, input pixel, output ready);
endinterface

interface bm3_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_pixel;
    logic       end_of_frame;

    modport source (output valid, output out_pixel, output end_of_frame, input ready);
    modport sink   (input valid, input out_pixel, input end_of_frame, output ready);
endinterface

`default_nettype wire

[rtl/core/binary_morphology_3x3.sv]
// binary_morphology_3x3: streaming 3x3 erosion / dilation over a raster frame.
// Depends on bm3_pkg (constants, types) and bm3_if (stream interfaces).
//
// Usage:
//   pixels  : one beat per item; kind = 0 carries a pixel in raster order,
//             kind = 1 is a flush tick. After the last pixel of a frame send
//             image_width + 1 flush ticks to drain the last row.
//   results : one beat per centre pixel with the AND (erosion) or OR
//             (dilation) of its 3x3 neighborhood; end_of_frame marks the last.
//   cfg     : cfg_write / cfg_index / cfg_data set mode, width and height;
//             write only while no item is in flight.
// Throughput: one item per clock while pixels.ready is high, set by the single
//   read port and single write port of each line store; a same-address read
//   right after a write (one-pixel rows) is served by a forwarding register.
// Output: the item that completes a neighborhood, one row plus one pixel after
//   its centre, is registered in the update stage, which pushes the result beat.
// Reset: counters clear, window fills with the erosion border, config takes
//   its reset values; line stores are not cleared.
// Stall: a four-beat result queue absorbs backpressure; pixels.ready drops
//   only when the queue plus the item in flight would overflow it.
`default_nettype none

module binary_morphology_3x3 #(
    parameter int MAX_WIDTH = bm3_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [bm3_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [bm3_pkg::CFG_DATA_W-1:0]  cfg_data,
    bm3_in_if.sink                              pixels,
    bm3_out_if.source                           results
);

    localparam int AW     = $clog2(MAX_WIDTH);
    localparam int WW_RAW = $clog2(MAX_WIDTH + 1);
    localparam int WW     = (WW_RAW > bm3_pkg::CFG_DATA_W) ? WW_RAW : bm3_pkg::CFG_DATA_W;
    localparam int RW     = bm3_pkg::ROW_W;
    localparam int QD     = bm3_pkg::QUEUE_DEPTH;
    localparam int QAW    = $clog2(QD);
    localparam int QCW    = $clog2(QD + 1);

    // Configuration registers
    logic                          mode_reg;
    logic [bm3_pkg::CFG_DATA_W-1:0] width_reg;
    logic [bm3_pkg::CFG_DATA_W-1:0] height_reg;

    // Position counters
    logic [AW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;

    // Update stage
    logic                 s1_valid_reg;
    bm3_pkg::stage_ctrl_t s1_ctrl_reg, s1_ctrl_next;
    logic [AW-1:0]        s1_addr_reg;
    logic [7:0]           s1_pixel_reg;

    // Line stores and their read data
    logic [7:0] older_mem [MAX_WIDTH];
    logic [7:0] newer_mem [MAX_WIDTH];
    logic [7:0] older_q_reg;
    logic [7:0] newer_q_reg;

    // Forwarding of a write to the address being read
    logic       fwd_reg, fwd_next;
    logic [7:0] fwd_older_reg;
    logic [7:0] fwd_newer_reg;

    // Window: middle and right columns (left column is never read again)
    logic [7:0] win_mid_reg   [3];
    logic [7:0] win_right_reg [3];
    logic [7:0] win_mid_next  [3];
    logic [7:0] win_right_next[3];

    // Result queue
    bm3_pkg::result_t queue_reg [QD];
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QCW-1:0]   count_reg;

    // Read-stage decode
    logic [WW-1:0] width_ext;
    logic [WW-1:0] w_eff;
    logic [bm3_pkg::CFG_DATA_W-1:0] h_eff;
    logic [RW-1:0] h_ext;
    logic          wrap;
    logic [AW-1:0] c0;
    logic [RW-1:0] r0;
    logic          drain;
    logic          skip;
    logic [WW-1:0] c_inc;
    logic          row_end;
    logic          accept;
    logic          launch;

    // Update-stage datapath
    logic [7:0]       border;
    logic [7:0]       older_rd;
    logic [7:0]       newer_rd;
    logic [7:0]       col_new [3];
    logic [7:0]       acc_and;
    logic [7:0]       acc_or;
    bm3_pkg::result_t res;
    logic             push;
    logic             pop;

    // Capture configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= bm3_pkg::MODE_RESET;
            width_reg  <= bm3_pkg::WIDTH_RESET;
            height_reg <= bm3_pkg::HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                bm3_pkg::CFG_MODE:   mode_reg   <= cfg_data[0];
                bm3_pkg::CFG_WIDTH:  width_reg  <= cfg_data;
                bm3_pkg::CFG_HEIGHT: height_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    // Decode the incoming item against the position counters
    always_comb
    begin
        width_ext = WW'(width_reg);
        if (width_reg == '0)
            w_eff = WW'(1);
        else if (width_ext > WW'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = width_ext;

        h_eff = (height_reg == '0) ? bm3_pkg::CFG_DATA_W'(1) : height_reg;
        h_ext = RW'(h_eff);

        // Start a new row when the width shrank below the column count
        wrap = (WW'(col_reg) >= w_eff);
        c0   = wrap ? '0 : col_reg;
        r0   = wrap ? row_reg + RW'(1) : row_reg;

        drain = (r0 >= h_ext);
        skip  = !drain && (pixels.kind == bm3_pkg::KIND_FLUSH);

        s1_ctrl_next.first_col = (c0 == '0);
        s1_ctrl_next.row_ge1   = (r0 >= RW'(1));
        s1_ctrl_next.row_ge2   = (r0 >= RW'(2));
        s1_ctrl_next.drain     = drain;
        s1_ctrl_next.emit      = (r0 >= RW'(2)) || ((r0 == RW'(1)) && (c0 != '0));
        s1_ctrl_next.finish    = (r0 >= h_ext + RW'(1));

        c_inc   = WW'(c0) + WW'(1);
        row_end = (c_inc >= w_eff);

        if (s1_ctrl_next.finish)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (row_end)
        begin
            col_next = '0;
            row_next = r0 + RW'(1);
        end
        else
        begin
            col_next = c_inc[AW-1:0];
            row_next = r0;
        end

        pixels.ready = ((QCW + 1)'(count_reg) + (QCW + 1)'(s1_valid_reg)) < (QCW + 1)'(QD);
        accept       = pixels.valid && pixels.ready;
        launch       = accept && !skip;
        fwd_next     = s1_valid_reg && (s1_addr_reg == c0);
    end

    // Advance counters and the update stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= launch;
            if (launch)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    // Hold item payload for the update stage
    always_ff @(posedge clk)
    begin
        if (launch)
        begin
            s1_ctrl_reg  <= s1_ctrl_next;
            s1_addr_reg  <= c0;
            s1_pixel_reg <= pixels.pixel;
        end
    end

    // Line stores: read at launch, write back in the update stage
    always_ff @(posedge clk)
    begin
        if (launch)
        begin
            older_q_reg   <= older_mem[c0];
            newer_q_reg   <= newer_mem[c0];
            fwd_reg       <= fwd_next;
            fwd_older_reg <= col_new[1];
            fwd_newer_reg <= col_new[2];
        end
        if (s1_valid_reg)
        begin
            older_mem[s1_addr_reg] <= col_new[1];
            newer_mem[s1_addr_reg] <= col_new[2];
        end
    end

    // Build the new column, fold the neighborhood and shift the window
    always_comb
    begin
        border   = (mode_reg == bm3_pkg::MODE_DILATE) ? bm3_pkg::BORDER_DILATE
                                                      : bm3_pkg::BORDER_ERODE;
        older_rd = fwd_reg ? fwd_older_reg : older_q_reg;
        newer_rd = fwd_reg ? fwd_newer_reg : newer_q_reg;

        col_new[0] = s1_ctrl_reg.row_ge2 ? older_rd : border;
        col_new[1] = s1_ctrl_reg.row_ge1 ? newer_rd : border;
        col_new[2] = s1_ctrl_reg.drain ? border : s1_pixel_reg;

        acc_and = 8'hFF;
        acc_or  = 8'h00;
        for (int i = 0; i < 3; i++)
        begin
            // A first column closes the previous row: its right side is border
            acc_and = acc_and & win_mid_reg[i] & win_right_reg[i]
                      & (s1_ctrl_reg.first_col ? border : col_new[i]);
            acc_or  = acc_or | win_mid_reg[i] | win_right_reg[i]
                      | (s1_ctrl_reg.first_col ? border : col_new[i]);
            win_mid_next[i]   = s1_ctrl_reg.first_col ? border : win_right_reg[i];
            win_right_next[i] = col_new[i];
        end

        res.out_pixel    = (mode_reg == bm3_pkg::MODE_DILATE) ? acc_or : acc_and;
        res.end_of_frame = s1_ctrl_reg.finish;
        push             = s1_valid_reg && (s1_ctrl_reg.emit || s1_ctrl_reg.finish);
    end

    // Window registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_mid_reg[i]   <= bm3_pkg::BORDER_ERODE;
                win_right_reg[i] <= bm3_pkg::BORDER_ERODE;
            end
        end
        else if (s1_valid_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_mid_reg[i]   <= win_mid_next[i];
                win_right_reg[i] <= win_right_next[i];
            end
        end
    end

    // Result queue control
    assign pop = results.valid && results.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            if (push && !pop)
                count_reg <= count_reg + QCW'(1);
            else if (pop && !push)
                count_reg <= count_reg - QCW'(1);
        end
    end

    // Result queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            queue_reg[wr_ptr_reg] <= res;
    end

    // Drive the result beat
    assign results.valid        = (count_reg != '0);
    assign results.out_pixel    = queue_reg[rd_ptr_reg].out_pixel;
    assign results.end_of_frame = queue_reg[rd_ptr_reg].end_of_frame;

endmodule

`default_nettype wire

[rtl/core/bm3_checker.sv]
// bm3_checker: port-level assertions for binary_morphology_3x3, bound to the top.
// Depends on the top level's ports only.
`default_nettype none

module bm3_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       pixels_valid,
    input wire logic       pixels_ready,
    input wire logic       results_valid,
    input wire logic       results_ready,
    input wire logic [7:0] results_out_pixel,
    input wire logic       results_end_of_frame
);

    // Hold a stalled result beat
    assert property (@(posedge clk) disable iff (!rst_n)
        results_valid && !results_ready |=> results_valid)
        else $error("result beat dropped while stalled");

    // Keep a stalled payload stable
    assert property (@(posedge clk) disable iff (!rst_n)
        results_valid && !results_ready |=>
            $stable(results_out_pixel) && $stable(results_end_of_frame))
        else $error("result payload changed while stalled");

    // A result appearing from empty comes from an earlier accepted input beat
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(results_valid) |-> $past(pixels_valid && pixels_ready, 2))
        else $error("result beat without a matching input beat");

    // Input backpressure only while results are pending
    assert property (@(posedge clk) disable iff (!rst_n)
        !pixels_ready |-> results_valid)
        else $error("input stalled with no result pending");

endmodule

bind binary_morphology_3x3 bm3_checker u_bm3_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .pixels_valid         (pixels.valid),
    .pixels_ready         (pixels.ready),
    .results_valid        (results.valid),
    .results_ready        (results.ready),
    .results_out_pixel    (results.out_pixel),
    .results_end_of_frame (results.end_of_frame)
);

`default_nettype wire
